FILE: src/cdqs_pkg.sv
// Shared constants, codes and types of the circular deque with search.
package cdqs_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 5;

   // operation codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH     = 3'd4;
   localparam logic [2:0] OP_SHOW       = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // cell commands
   localparam logic [2:0] CMD_HOLD       = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_ROTATE     = 3'd4;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [POS_W-1:0]   position;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

endpackage

FILE: src/cdqs_cell.sv
// One storage cell of the deque chain; cell 0 holds the front element.
module cdqs_cell (
   input  logic                        clock,
   input  cdqs_pkg::cell_ctrl_type     ctrl,
   input  logic [cdqs_pkg::IDX_W-1:0]  cell_index,
   input  logic signed [31:0]          value,
   input  logic signed [31:0]          left_data,
   input  logic signed [31:0]          right_data,
   input  logic signed [31:0]          head_data,
   output logic signed [31:0]          data
);
   import cdqs_pkg::*;

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   logic [CNT_W-1:0]   pos;
   logic [CNT_W-1:0]   pos_next;

   assign pos      = CNT_W'(cell_index);
   assign pos_next = pos + CNT_W'(1);

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CMD_PUSH_FRONT: data_in = left_data;
         CMD_PUSH_BACK: begin
            if (pos == ctrl.count) data_in = value;
         end
         CMD_POP_FRONT: data_in = right_data;
         CMD_ROTATE: begin
            // wrap the occupied prefix: the last occupied cell takes the head
            if (pos_next == ctrl.count) data_in = head_data;
            else if (pos_next < ctrl.count) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: src/circular_deque_with_search.sv
// Top level of the circular deque with search: control and the chain of cells.
//
// Requests arrive on req_valid/req_stall with req.operation and req.value;
// results leave on rsp_valid/rsp_stall. Both sides move a request at a rising
// edge with valid high and stall low.
// Push and pop give one result, registered as the request is taken.
// Search walks the stored elements (at most 16) once, one per cycle, rotating
// the chain through cell 0, and gives its single result when the walk ends.
// Show gives one result per stored element, one per cycle while the receiver
// takes them, the final one with last set; an empty deque gives a single
// empty result. Operation codes 6 and 7 are taken and give nothing.
// One request is in work at a time: req_stall is high during a walk and while
// a result waits on a stalled receiver. A rsp stall freezes the walk in place.
// Reset (synchronous, active high) empties the deque; stored data is not
// cleared and is never read before being written.
module circular_deque_with_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdqs_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdqs_pkg::rsp_type rsp
);
   import cdqs_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic signed [31:0] key_ff, key_in;
   logic               show_ff, show_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free;
   logic               accept;
   logic               emit;
   logic               hit;
   logic               last_step;
   logic [CNT_W-1:0]   step_next;
   cell_ctrl_type      ctrl;
   logic signed [31:0] cell_data [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         cdqs_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(i)),
            .value      (req.value),
            .left_data  ((i == 0) ? req.value : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data ((i == DEPTH - 1) ? cell_data[i]
                                          : cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
         );
      end
   endgenerate

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign step_next = step_ff + CNT_W'(1);
   assign hit       = (cell_data[0] == key_ff);
   assign last_step = (step_next == count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      key_in   = key_ff;
      show_in  = show_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      ctrl.cmd   = CMD_HOLD;
      ctrl.count = count_ff;
      emit     = 1'b0;
      rsp_in   = '{status: ST_OK, position: '0, element: '0, last: 1'b1};

      if (state_ff == ST_IDLE) begin
         if (accept) begin
            case (req.operation)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  emit = 1'b1;
                  if (count_ff == CNT_W'(DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ctrl.cmd = (req.operation == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                 : CMD_PUSH_BACK;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  emit = 1'b1;
                  if (count_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     if (req.operation == OP_POP_FRONT) ctrl.cmd = CMD_POP_FRONT;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               OP_SEARCH, OP_SHOW: begin
                  if (count_ff == '0) begin
                     emit          = 1'b1;
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     state_in = ST_WALK;
                     step_in  = '0;
                     key_in   = req.value;
                     show_in  = (req.operation == OP_SHOW);
                     found_in = 1'b0;
                     pos_in   = '0;
                  end
               end
               default: ;
            endcase
         end
      end else if (out_free) begin
         // advance one element; the chain is back in place after count steps
         ctrl.cmd = CMD_ROTATE;
         step_in  = step_next;
         if (!found_ff && hit) begin
            found_in = 1'b1;
            pos_in   = POS_W'(step_next);
         end
         if (show_ff) begin
            emit           = 1'b1;
            rsp_in.element = cell_data[0];
            rsp_in.last    = last_step;
         end
         if (last_step) begin
            state_in = ST_IDLE;
            if (!show_ff) begin
               emit = 1'b1;
               if (found_ff) begin
                  rsp_in.status   = ST_FOUND;
                  rsp_in.position = pos_ff;
               end else if (hit) begin
                  rsp_in.status   = ST_FOUND;
                  rsp_in.position = POS_W'(step_next);
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      show_ff <= show_in;
      pos_ff  <= pos_in;
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_walk_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> req_stall)
      else $error("request taken during a walk");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (step_ff < count_ff))
      else $error("walk step beyond fill count");

   a_count_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |=> count_ff == $past(count_ff))
      else $error("fill count changed during a walk");

endmodule
